[rtl/core/integer_to_radix_digits_macros.svh]
// Assertion helpers used by the conversion back end (i2r_back).
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Condition that holds at every edge out of reset.
`define I2R_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define I2R_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2R_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2r_pkg.sv]
package i2r_pkg;

  localparam int ValueWidth = 63;
  localparam int BaseWidth  = 5;
  localparam int DigitWidth = 4;
  localparam int CharWidth  = 7;
  localparam int MaxDigits  = 63;
  localparam int CntWidth   = 6;
  localparam int ByteWidth  = 8;
  localparam int NumBytes   = 8;
  localparam int WorkWidth  = ByteWidth * NumBytes;
  localparam int IdxWidth   = 3;

  localparam logic [BaseWidth-1:0] BaseReset = 5'd10;
  localparam logic [BaseWidth-1:0] BaseMin   = 5'd2;
  localparam logic [BaseWidth-1:0] BaseMax   = 5'd16;

  localparam logic [CharWidth-1:0] CharZero = 7'h30;
  localparam logic [CharWidth-1:0] CharA    = 7'h41;

  localparam int QueueDepthDefault = 2;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [BaseWidth-1:0]  base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [CharWidth-1:0] to_ascii(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d < 4'd10) begin
      c = CharZero + {3'b000, d};
    end else begin
      c = CharA + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

[rtl/core/i2r_front.sv]
module i2r_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2r_pkg::BaseWidth-1:0]  cfg_wdata_i,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [i2r_pkg::ValueWidth-1:0] s_value_i,
  input  i2r_pkg::qstat_t                qstat_i,
  output logic                           push_o,
  output i2r_pkg::job_t                  job_o
);

  logic [i2r_pkg::BaseWidth-1:0] base_q;
  logic [i2r_pkg::BaseWidth-1:0] base_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= i2r_pkg::BaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // out-of-range radix folds to the nearest supported one
  always_comb begin
    if (base_q < i2r_pkg::BaseMin) begin
      base_eff = i2r_pkg::BaseMin;
    end else if (base_q > i2r_pkg::BaseMax) begin
      base_eff = i2r_pkg::BaseMax;
    end else begin
      base_eff = base_q;
    end
  end

  assign s_ready_o   = !qstat_i.full;
  assign push_o      = s_valid_i && !qstat_i.full;
  assign job_o.value = s_value_i;
  assign job_o.base  = base_eff;

endmodule

[rtl/core/i2r_queue.sv]
module i2r_queue #(
  parameter int Depth = i2r_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2r_pkg::job_t   job_i,
  input  logic            pop_i,
  output i2r_pkg::job_t   job_o,
  output i2r_pkg::qstat_t qstat_o
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW     = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntW-1:0]     Full    = CntW'(Depth);

  i2r_pkg::job_t        mem_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign qstat_o.full  = (cnt_q == Full);
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign job_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[rtl/core/i2r_back.sv]
`include "integer_to_radix_digits_macros.svh"

module i2r_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2r_pkg::job_t                 job_i,
  input  i2r_pkg::qstat_t               qstat_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [i2r_pkg::CharWidth-1:0] m_char_o,
  output logic                          m_last_o
);

  localparam int BW = i2r_pkg::ByteWidth;
  localparam int NB = i2r_pkg::NumBytes;
  localparam int MD = i2r_pkg::MaxDigits;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e                            state_q, state_d;
  logic [i2r_pkg::WorkWidth-1:0]     val_q, val_d;
  logic [i2r_pkg::BaseWidth-1:0]     base_q, base_d;
  logic [i2r_pkg::DigitWidth-1:0]    rem_q, rem_d;
  logic [i2r_pkg::IdxWidth-1:0]      idx_q, idx_d, top_q, top_d;
  logic [i2r_pkg::CntWidth-1:0]      cnt_q, cnt_d;
  logic [i2r_pkg::DigitWidth-1:0]    stack_q [MD];
  logic [i2r_pkg::DigitWidth-1:0]    stack_d [MD];
  logic                              out_valid_q, out_valid_d;
  logic [i2r_pkg::CharWidth-1:0]     out_char_q, out_char_d;
  logic                              out_last_q, out_last_d;

  logic [BW-1:0]                     cur_byte, quo_byte;
  logic [i2r_pkg::DigitWidth-1:0]    rem_out;
  logic [i2r_pkg::WorkWidth-1:0]     new_val, load_val;
  logic [i2r_pkg::IdxWidth-1:0]      load_top, top_next;
  logic                              out_free;

  assign cur_byte = val_q[{idx_q, 3'b000} +: BW];

  // one byte of long division per cycle; remainder stays below the base
  always_comb begin
    logic [i2r_pkg::BaseWidth-1:0] t;
    t = {1'b0, rem_q};
    quo_byte = '0;
    for (int i = BW - 1; i >= 0; i--) begin
      t = {t[i2r_pkg::DigitWidth-1:0], cur_byte[i]};
      if (t >= base_q) begin
        t = t - base_q;
        quo_byte[i] = 1'b1;
      end
    end
    rem_out = t[i2r_pkg::DigitWidth-1:0];
  end

  always_comb begin
    new_val = val_q;
    new_val[{idx_q, 3'b000} +: BW] = quo_byte;
  end

  // quotient shrinks by at most four bits per digit (base at most 16), so at most one byte drops
  assign top_next = ((new_val[{top_q, 3'b000} +: BW] == '0) && (top_q != '0)) ?
                    top_q - 1'b1 : top_q;

  always_comb begin
    load_val = {1'b0, job_i.value};
    load_top = '0;
    for (int j = 0; j < NB; j++) begin
      if (load_val[j*BW +: BW] != '0) begin
        load_top = i2r_pkg::IdxWidth'(j);
      end
    end
  end

  assign out_free = !out_valid_q || m_ready_i;
  assign pop_o    = (state_q == StIdle) && !qstat_i.empty;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    base_d      = base_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    stack_d     = stack_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (!qstat_i.empty) begin
          val_d   = load_val;
          base_d  = job_i.base;
          rem_d   = '0;
          top_d   = load_top;
          idx_d   = load_top;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        val_d = new_val;
        if (idx_q != '0) begin
          rem_d = rem_out;
          idx_d = idx_q - 1'b1;
        end else begin
          // digits come out LSB first; push so the MSB ends on top
          stack_d[0] = rem_out;
          for (int k = 1; k < MD; k++) begin
            stack_d[k] = stack_q[k-1];
          end
          cnt_d = cnt_q + 1'b1;
          rem_d = '0;
          top_d = top_next;
          idx_d = top_next;
          if (new_val == '0) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = i2r_pkg::to_ascii(stack_q[0]);
          out_last_d  = (cnt_q == i2r_pkg::CntWidth'(1));
          for (int k = 0; k < MD - 1; k++) begin
            stack_d[k] = stack_q[k+1];
          end
          stack_d[MD-1] = '0;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == i2r_pkg::CntWidth'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      val_q       <= '0;
      base_q      <= i2r_pkg::BaseReset;
      rem_q       <= '0;
      idx_q       <= '0;
      top_q       <= '0;
      cnt_q       <= '0;
      stack_q     <= '{default: '0};
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      val_q       <= val_d;
      base_q      <= base_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      stack_q     <= stack_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;

  `I2R_ASSERT_IMP(a_rem_below_base, state_q == StDiv, i2r_pkg::BaseWidth'(rem_q) < base_q,
                  "remainder >= base")
  `I2R_ASSERT_IMP(a_base_range, state_q != StIdle,
                  base_q >= i2r_pkg::BaseMin && base_q <= i2r_pkg::BaseMax, "base out of range")
  `I2R_ASSERT(a_cnt_bound, cnt_q <= i2r_pkg::CntWidth'(MD), "digit stack overflow")
  `I2R_ASSERT_NXT(a_last_on_final, state_q == StEmit && out_free && cnt_q == i2r_pkg::CntWidth'(1),
                  out_valid_q && out_last_q && state_q == StIdle, "final digit not flagged")
  `I2R_ASSERT_IMP(a_no_empty_emit, state_q == StEmit, cnt_q != '0, "emit with empty stack")

endmodule

[rtl/core/integer_to_radix_digits.sv]
// Converts each 63-bit unsigned word on the input stream into its digits in the
// radix held in the base register (2..16; 0 and 1 act as 2, 17..31 as 16), sent
// most significant first as upper-case ASCII, one digit per output word, with
// tlast on the final digit. Zero yields a single '0'. A small queue takes new
// words while the converter is busy; the base is sampled when a word is taken.
// Per number: a load step, then for each digit a pass of the byte-wide division
// unit over each active byte of the remaining quotient (1..8 bytes), then the
// digits are sent out. Digits drain at one per cycle while the sink is ready.
// Write cfg only while no conversion is in flight.
module integer_to_radix_digits #(
  parameter int QueueDepth = i2r_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2r_pkg::BaseWidth-1:0] cfg_wdata_i,    // base
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [63:0]                   s_axis_tdata_i, // [62:0] value, [63] zero
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o, // [6:0] digit_char, [7] zero
  output logic                          m_axis_tlast_o  // last
);

  i2r_pkg::job_t                 push_job, head_job;
  i2r_pkg::qstat_t               qstat;
  logic                          push, pop;
  logic [i2r_pkg::CharWidth-1:0] out_char;

  i2r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_value_i   (s_axis_tdata_i[i2r_pkg::ValueWidth-1:0]),
    .qstat_i     (qstat),
    .push_o      (push),
    .job_o       (push_job)
  );

  i2r_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  i2r_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .qstat_i   (qstat),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (out_char),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule

[test/tb_integer_to_radix_digits.sv]
`timescale 1ns / 100ps

module tb_integer_to_radix_digits;

  localparam int          HalfPeriod  = 10;
  localparam int          HoldCycles  = 300;
  localparam int          IdleLimit   = 3000;
  localparam int          TailCycles  = 400;
  localparam int          ReportMax   = 10;
  localparam int          IdlePercent = 17;
  localparam logic [62:0] ValueMax    = {63{1'b1}};
  localparam logic [6:0]  AsciiZero   = 7'h30;
  localparam logic [6:0]  AsciiUpperA = 7'h41;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_last;
  } digit_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [i2r_pkg::BaseWidth-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [63:0]                   s_axis_tdata_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [7:0]                    m_axis_tdata_o;
  logic                          m_axis_tlast_o;

  // Mirror of the base register and the digits still owed by the block.
  logic [4:0] radix_reg = 5'd10;
  digit_t     digit_q[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         hold_asked  = 0;
  int         hold_taken  = 0;
  bit         quiet       = 1'b0;

  integer_to_radix_digits u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic logic [4:0] eff_radix(input logic [4:0] r);
    if (r < 5'd2) return 5'd2;
    if (r > 5'd16) return 5'd16;
    return r;
  endfunction

  // Queue the digits of v, most significant first, in the current radix.
  function automatic void expand_digits(input logic [62:0] v);
    logic [3:0]  digs[63];
    logic [62:0] rest;
    logic [4:0]  b;
    digit_t      d;
    int          n;
    b = eff_radix(radix_reg);
    rest = v;
    n = 0;
    do begin
      digs[n] = 4'(rest % b);
      rest = rest / b;
      n++;
    end while (rest != 0 && n < 63);
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] < 4'd10) d.ch = AsciiZero + 7'(digs[k]);
      else d.ch = AsciiUpperA + 7'(digs[k]) - 7'd10;
      d.is_last = (k == 0);
      digit_q.push_back(d);
    end
  endfunction

  function automatic logic [62:0] rand_full();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // Mix of full-width, short, tiny and near-power-of-radix numbers, and zero.
  function automatic logic [62:0] pick_value();
    logic [62:0] v;
    logic [63:0] p;
    logic [4:0]  b;
    int          rb;
    int          sel;
    b = eff_radix(radix_reg);
    rb = b;
    sel = $urandom_range(99);
    v = rand_full();
    if (sel < 30) begin
      v = v;
    end else if (sel < 60) begin
      v = v >> $urandom_range(62);
    end else if (sel < 75) begin
      v = 63'($urandom_range(rb * rb));
    end else if (sel < 95) begin
      p = 64'd1;
      repeat ($urandom_range(1, 62)) if (p <= ValueMax / b) p = p * b;
      v = p[62:0] + 63'($urandom_range(2)) - 63'd1;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input digit_t want,
                                        input digit_t got);
    if (mismatches < ReportMax) begin
      $display("%0t %s: expected '%c' last=%b, got '%c' last=%b", $realtime, what,
               want.ch, want.is_last, got.ch, got.is_last);
    end
    mismatches++;
  endfunction

  // Offer one word; returns at the edge where it is taken.
  task automatic send_value(input logic [62:0] v);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, v};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expand_digits(v);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain_digits();
    while (digit_q.size() != 0) @(posedge clk_i);
  endtask

  // Every word yields at least one digit, so an empty queue means idle.
  task automatic set_radix(input logic [4:0] r);
    stop_sending();
    drain_digits();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    radix_reg = r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_radix();
    send_value('0);
    send_value(63'd1);
    send_value(63'd9);
    send_value(63'd10);
    send_value(63'd999_999_999_999_999_999);
    send_value(ValueMax);
  endtask

  task automatic test_radix_extremes();
    set_radix(5'd2);
    send_value('0);
    send_value(63'd1);
    send_value(63'h4000_0000_0000_0000);
    send_value(ValueMax);
    set_radix(5'd16);
    send_value('0);
    send_value(63'd15);
    send_value(63'd16);
    send_value(63'h7EDC_BA98_7654_3210);
    send_value(ValueMax);
    // below two acts as binary, above sixteen as hex
    set_radix(5'd0);
    send_value(63'd6);
    send_value(ValueMax);
    set_radix(5'd1);
    send_value(63'd3);
    set_radix(5'd17);
    send_value(63'hFA);
    set_radix(5'd31);
    send_value(63'h0123_4567_89AB_CDEF);
    set_radix(5'd3);
    send_value('0);
    send_value(ValueMax);
  endtask

  task automatic test_random_values();
    logic [4:0] plan[12];
    plan = '{5'd3, 5'd5, 5'd7, 5'd8, 5'd11, 5'd12, 5'd13, 5'd15, 5'd9, 5'd4, 5'd6, 5'd14};
    for (int ph = 0; ph < 13; ph++) begin
      set_radix(ph < 12 ? plan[ph] : 5'($urandom_range(31)));
      quiet = (ph == 5);
      for (int i = 0; i < 7; i++) begin
        if (ph == 3 && i == 4) begin
          stop_sending();
          drain_digits();
        end
        send_value(pick_value());
      end
    end
    quiet = 1'b0;
  endtask

  // Sink stalls for a long stretch while words keep coming.
  task automatic test_output_backpressure();
    set_radix(5'd10);
    hold_asked++;
    for (int i = 0; i < 12; i++) send_value(63'($urandom_range(9999)));
  endtask

  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= quiet || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin : check_digits
    digit_t want;
    digit_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.ch      = m_axis_tdata_o[6:0];
      got.is_last = m_axis_tlast_o;
      if (digit_q.size() == 0) begin
        note_mismatch("unexpected digit", '0, got);
      end else begin
        want = digit_q.pop_front();
        if (got.ch !== want.ch || got.is_last !== want.is_last) begin
          note_mismatch("digit mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_integer_to_radix_digits NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_radix();
    test_radix_extremes();
    test_random_values();
    test_output_backpressure();

    stop_sending();
    drain_digits();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_integer_to_radix_digits OK");
    end else begin
      $display("tb_integer_to_radix_digits NOT OK");
    end
    $finish;
  end

endmodule
